FILE: rtl/core/mini_c_lexer_macros.svh
// Assertion macros shared by the lexer RTL.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef MINI_C_LEXER_MACROS_SVH
`define MINI_C_LEXER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define MCL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mini_c_lexer check failed");
// Next-cycle implication, disabled during reset
`define MCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mini_c_lexer check failed");
`else
`define MCL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/mcl_pkg.sv
// Shared types, token codes and keyword tables of the mini C lexer.
// No dependencies; mcl_lex_step, mcl_res_fifo and mini_c_lexer refer to it by scoped names.
package mcl_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int LENGTH_BITS_DEF   = 8;
	localparam int FIFO_DEPTH        = 4;
	localparam int KW_COUNT          = 6;

	// Token codes
	localparam logic signed [5:0] TOK_IDENT   = 6'sd0;
	localparam logic signed [5:0] TOK_CHAR    = 6'sd1;
	localparam logic signed [5:0] TOK_STRING  = 6'sd2;
	localparam logic signed [5:0] TOK_NUMBER  = 6'sd3;
	localparam logic signed [5:0] TOK_GE      = 6'sd10;
	localparam logic signed [5:0] TOK_LE      = 6'sd11;
	localparam logic signed [5:0] TOK_EQ      = 6'sd12;
	localparam logic signed [5:0] TOK_ASSIGN  = 6'sd13;
	localparam logic signed [5:0] TOK_GT      = 6'sd14;
	localparam logic signed [5:0] TOK_LT      = 6'sd15;
	localparam logic signed [5:0] TOK_PLUS    = 6'sd16;
	localparam logic signed [5:0] TOK_MINUS   = 6'sd17;
	localparam logic signed [5:0] TOK_STAR    = 6'sd18;
	localparam logic signed [5:0] TOK_SLASH   = 6'sd19;
	localparam logic signed [5:0] TOK_LBRACE  = 6'sd20;
	localparam logic signed [5:0] TOK_RBRACE  = 6'sd21;
	localparam logic signed [5:0] TOK_COMMA   = 6'sd22;
	localparam logic signed [5:0] TOK_SEMI    = 6'sd23;
	localparam logic signed [5:0] TOK_LPAREN  = 6'sd24;
	localparam logic signed [5:0] TOK_RPAREN  = 6'sd25;
	localparam logic signed [5:0] TOK_SQUOTE  = 6'sd26;
	localparam logic signed [5:0] TOK_DQUOTE  = 6'sd27;
	localparam logic signed [5:0] TOK_LBRACK  = 6'sd28;
	localparam logic signed [5:0] TOK_RBRACK  = 6'sd29;
	localparam logic signed [5:0] TOK_UNKNOWN = -6'sd1;
	localparam logic signed [5:0] TOK_NONE    = 6'sd0;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_REL,
		MODE_QUOTE
	} lex_mode_t;

	// Fixed-width part of the lexer state
	typedef struct packed {
		lex_mode_t   mode;
		logic [5:0]  kw_set;
		logic [4:0]  rel_code;
		logic        quote_kind;
	} lex_ctl_t;

	localparam logic [7:0] KW_TEXT [KW_COUNT][4] = '{
		'{"i", "n", "t", 8'h00},
		'{"m", "a", "i", "n"},
		'{"v", "o", "i", "d"},
		'{"i", "f", 8'h00, 8'h00},
		'{"e", "l", "s", "e"},
		'{"c", "h", "a", "r"}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd4, 3'd4, 3'd2, 3'd4, 3'd4};
	localparam logic signed [5:0] KW_CODE [KW_COUNT] =
		'{6'sd4, 6'sd5, 6'sd6, 6'sd7, 6'sd8, 6'sd9};

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// Narrow the set of keywords still matching by char c at index idx
	function automatic logic [5:0] kw_next(logic [5:0] set, logic [2:0] idx,
		logic [7:0] c);
		logic [5:0] nxt;
		nxt = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (set[k] && idx < KW_LEN[k] && KW_TEXT[k][idx[1:0]] == c)
				nxt[k] = 1'b1;
		end
		return nxt;
	endfunction

	// Keyword code on a full match at index idx, TOK_NONE otherwise
	function automatic logic signed [5:0] kw_hit(logic [5:0] set, logic [2:0] idx);
		logic signed [5:0] code;
		code = TOK_NONE;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (set[k] && {1'b0, KW_LEN[k]} == {1'b0, idx} + 4'd1)
				code = KW_CODE[k];
		end
		return code;
	endfunction

	function automatic logic signed [5:0] symbol_code(logic [7:0] c);
		logic signed [5:0] code;
		case (c)
			"+": code = TOK_PLUS;
			"-": code = TOK_MINUS;
			"*": code = TOK_STAR;
			"/": code = TOK_SLASH;
			"{": code = TOK_LBRACE;
			"}": code = TOK_RBRACE;
			",": code = TOK_COMMA;
			";": code = TOK_SEMI;
			"(": code = TOK_LPAREN;
			")": code = TOK_RPAREN;
			"[": code = TOK_LBRACK;
			"]": code = TOK_RBRACK;
			default: code = TOK_UNKNOWN;
		endcase
		return code;
	endfunction

endpackage

FILE: rtl/core/mcl_if.sv
// Valid/ready channel interfaces: source characters in, tokens out.
// Depends on nothing; token widths are interface parameters.
interface mcl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       is_end;

	modport source (output valid, output in_char, output is_end, input ready);
	modport sink   (input valid, input in_char, input is_end, output ready);
endinterface

interface mcl_token_if #(
	parameter int POSITION_BITS = 16,
	parameter int LENGTH_BITS   = 8
);
	logic                     valid;
	logic                     ready;
	logic signed [5:0]        token_code;
	logic [POSITION_BITS-1:0] token_start;
	logic [LENGTH_BITS-1:0]   token_length;
	logic                     last_of_run;

	modport source (output valid, output token_code, output token_start,
		output token_length, output last_of_run, input ready);
	modport sink   (input valid, input token_code, input token_start,
		input token_length, input last_of_run, output ready);
endinterface

FILE: rtl/core/mcl_lex_step.sv
// One lexer step: next state and up to two tokens for one character word.
// Pure combinational logic; uses mcl_pkg tables and types.
module mcl_lex_step #(
	parameter int POSITION_BITS = mcl_pkg::POSITION_BITS_DEF,
	parameter int LENGTH_BITS   = mcl_pkg::LENGTH_BITS_DEF
) (
	input  logic [7:0]               in_char,
	input  logic                     is_end,
	input  mcl_pkg::lex_ctl_t        ctl,
	input  logic [POSITION_BITS-1:0] start_pos,
	input  logic [LENGTH_BITS-1:0]   run_len,
	input  logic [POSITION_BITS-1:0] char_pos,
	output mcl_pkg::lex_ctl_t        ctl_nx,
	output logic [POSITION_BITS-1:0] start_pos_nx,
	output logic [LENGTH_BITS-1:0]   run_len_nx,
	output logic [POSITION_BITS-1:0] char_pos_nx,
	output logic [1:0]               res_count,
	output logic signed [5:0]        res_code  [2],
	output logic [POSITION_BITS-1:0] res_start [2],
	output logic [LENGTH_BITS-1:0]   res_len   [2]
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
	localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);

	logic                     alnum;
	logic                     ident_cont;
	logic [5:0]               kw_in;
	logic [2:0]               kw_idx;
	logic [5:0]               kw_nxt;
	logic signed [5:0]        kw_code;
	logic [LENGTH_BITS-1:0]   run_inc;
	logic [POSITION_BITS-1:0] pos_inc;
	logic signed [5:0]        quote_code;

	assign alnum      = mcl_pkg::is_letter(in_char) || mcl_pkg::is_digit(in_char);
	assign ident_cont = (ctl.mode == mcl_pkg::MODE_IDENT) && alnum;
	assign run_inc    = (run_len == LEN_MAX) ? LEN_MAX : run_len + LEN_ONE;
	assign pos_inc    = char_pos + POSITION_BITS'(1);
	assign quote_code = ctl.quote_kind ? mcl_pkg::TOK_DQUOTE : mcl_pkg::TOK_SQUOTE;

	// Share one keyword matcher between continuing and starting an identifier
	assign kw_in   = ident_cont ? ctl.kw_set : 6'h3F;
	assign kw_idx  = !ident_cont ? 3'd0 :
		(run_len > LENGTH_BITS'(7)) ? 3'd7 : run_len[2:0];
	assign kw_nxt  = mcl_pkg::kw_next(kw_in, kw_idx, in_char);
	assign kw_code = mcl_pkg::kw_hit(kw_nxt, kw_idx);

	always_comb begin
		logic [1:0]               m_n;
		logic signed [5:0]        m_code [2];
		logic [POSITION_BITS-1:0] m_start [2];
		logic [LENGTH_BITS-1:0]   m_len [2];
		logic                     f_v;
		logic signed [5:0]        f_code;
		logic [POSITION_BITS-1:0] f_start;
		logic                     consumed;

		m_n        = 2'd0;
		m_code     = '{mcl_pkg::TOK_NONE, mcl_pkg::TOK_NONE};
		m_start    = '{'0, '0};
		m_len      = '{'0, '0};
		f_v        = 1'b0;
		f_code     = mcl_pkg::TOK_NONE;
		f_start    = char_pos;
		consumed   = 1'b0;
		ctl_nx       = ctl;
		start_pos_nx = start_pos;
		run_len_nx   = run_len;
		char_pos_nx  = char_pos;

		if (is_end) begin
			// Flush whatever is pending, then return to reset state
			case (ctl.mode)
				mcl_pkg::MODE_IDENT: begin
					m_n = 2'd1;
					m_code[0] = mcl_pkg::TOK_IDENT;
					m_start[0] = start_pos;
					m_len[0] = run_len;
				end
				mcl_pkg::MODE_NUMBER: begin
					m_n = 2'd1;
					m_code[0] = mcl_pkg::TOK_NUMBER;
					m_start[0] = start_pos;
					m_len[0] = run_len;
				end
				mcl_pkg::MODE_REL: begin
					m_n = 2'd1;
					m_code[0] = $signed({1'b0, ctl.rel_code});
					m_start[0] = start_pos;
					m_len[0] = LEN_ONE;
				end
				mcl_pkg::MODE_QUOTE: begin
					m_n = 2'd2;
					m_code[0] = ctl.quote_kind ? mcl_pkg::TOK_STRING : mcl_pkg::TOK_CHAR;
					m_start[0] = start_pos;
					m_len[0] = run_len;
					m_code[1] = quote_code;
					m_start[1] = char_pos;
					m_len[1] = LEN_ONE;
				end
				default: m_n = 2'd0;
			endcase
			ctl_nx.mode       = mcl_pkg::MODE_IDLE;
			ctl_nx.kw_set     = '0;
			ctl_nx.rel_code   = '0;
			ctl_nx.quote_kind = 1'b0;
			start_pos_nx      = '0;
			run_len_nx        = '0;
			char_pos_nx       = '0;
		end else if (!mcl_pkg::is_space(in_char)) begin
			char_pos_nx = pos_inc;
			// Continue or close the pending token
			case (ctl.mode)
				mcl_pkg::MODE_IDENT: begin
					if (alnum) begin
						run_len_nx = run_inc;
						ctl_nx.kw_set = kw_nxt;
						if (kw_code != mcl_pkg::TOK_NONE) begin
							m_n = 2'd1;
							m_code[0] = kw_code;
							m_start[0] = start_pos;
							m_len[0] = run_inc;
							ctl_nx.mode = mcl_pkg::MODE_IDLE;
						end
						consumed = 1'b1;
					end else begin
						m_n = 2'd1;
						m_code[0] = mcl_pkg::TOK_IDENT;
						m_start[0] = start_pos;
						m_len[0] = run_len;
						ctl_nx.mode = mcl_pkg::MODE_IDLE;
					end
				end
				mcl_pkg::MODE_NUMBER: begin
					if (mcl_pkg::is_digit(in_char)) begin
						run_len_nx = run_inc;
						consumed = 1'b1;
					end else begin
						m_n = 2'd1;
						m_code[0] = mcl_pkg::TOK_NUMBER;
						m_start[0] = start_pos;
						m_len[0] = run_len;
						ctl_nx.mode = mcl_pkg::MODE_IDLE;
					end
				end
				mcl_pkg::MODE_REL: begin
					m_n = 2'd1;
					m_start[0] = start_pos;
					if (in_char == "=") begin
						m_code[0] = (ctl.rel_code == mcl_pkg::TOK_ASSIGN[4:0]) ? mcl_pkg::TOK_EQ :
							(ctl.rel_code == mcl_pkg::TOK_GT[4:0]) ? mcl_pkg::TOK_GE :
							mcl_pkg::TOK_LE;
						m_len[0] = LEN_TWO;
						consumed = 1'b1;
					end else begin
						m_code[0] = $signed({1'b0, ctl.rel_code});
						m_len[0] = LEN_ONE;
					end
					ctl_nx.mode = mcl_pkg::MODE_IDLE;
				end
				mcl_pkg::MODE_QUOTE: begin
					if (mcl_pkg::is_letter(in_char)) begin
						run_len_nx = run_inc;
					end else begin
						m_n = 2'd2;
						m_code[0] = ctl.quote_kind ? mcl_pkg::TOK_STRING : mcl_pkg::TOK_CHAR;
						m_start[0] = start_pos;
						m_len[0] = run_len;
						m_code[1] = quote_code;
						m_start[1] = char_pos;
						m_len[1] = LEN_ONE;
						ctl_nx.mode = mcl_pkg::MODE_IDLE;
					end
					consumed = 1'b1;
				end
				default: ctl_nx.mode = mcl_pkg::MODE_IDLE;
			endcase

			// Lex the character afresh when it was not taken above
			if (!consumed) begin
				start_pos_nx = char_pos;
				run_len_nx   = LEN_ONE;
				f_start      = char_pos;
				if (mcl_pkg::is_letter(in_char)) begin
					ctl_nx.mode   = mcl_pkg::MODE_IDENT;
					ctl_nx.kw_set = kw_nxt;
					if (kw_code != mcl_pkg::TOK_NONE) begin
						f_v = 1'b1;
						f_code = kw_code;
						ctl_nx.mode = mcl_pkg::MODE_IDLE;
					end
				end else if (mcl_pkg::is_digit(in_char)) begin
					ctl_nx.mode = mcl_pkg::MODE_NUMBER;
				end else if (in_char == "=" || in_char == ">" || in_char == "<") begin
					ctl_nx.mode = mcl_pkg::MODE_REL;
					ctl_nx.rel_code = (in_char == "=") ? mcl_pkg::TOK_ASSIGN[4:0] :
						(in_char == ">") ? mcl_pkg::TOK_GT[4:0] : mcl_pkg::TOK_LT[4:0];
				end else if (in_char == "'" || in_char == "\"") begin
					ctl_nx.quote_kind = (in_char == "\"");
					ctl_nx.mode = mcl_pkg::MODE_QUOTE;
					f_v = 1'b1;
					f_code = (in_char == "\"") ? mcl_pkg::TOK_DQUOTE : mcl_pkg::TOK_SQUOTE;
					start_pos_nx = pos_inc;
					run_len_nx = '0;
				end else begin
					f_v = 1'b1;
					f_code = mcl_pkg::symbol_code(in_char);
				end
			end
		end

		// Order tokens: closing ones first, then the fresh one
		res_count    = m_n + {1'b0, f_v};
		res_code[0]  = (m_n != 2'd0) ? m_code[0] : f_code;
		res_start[0] = (m_n != 2'd0) ? m_start[0] : f_start;
		res_len[0]   = (m_n != 2'd0) ? m_len[0] : LEN_ONE;
		res_code[1]  = (m_n == 2'd2) ? m_code[1] : f_code;
		res_start[1] = (m_n == 2'd2) ? m_start[1] : f_start;
		res_len[1]   = (m_n == 2'd2) ? m_len[1] : LEN_ONE;
	end

endmodule

FILE: rtl/core/mcl_res_fifo.sv
// Token queue: takes up to two tokens per cycle, hands out one per out_ready cycle.
// Register array with head/tail pointers; uses mcl_pkg and the macro header.
`include "mini_c_lexer_macros.svh"
module mcl_res_fifo #(
	parameter int POSITION_BITS = mcl_pkg::POSITION_BITS_DEF,
	parameter int LENGTH_BITS   = mcl_pkg::LENGTH_BITS_DEF,
	parameter int DEPTH         = mcl_pkg::FIFO_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [1:0]               push_count,
	input  logic signed [5:0]        push_code  [2],
	input  logic [POSITION_BITS-1:0] push_start [2],
	input  logic [LENGTH_BITS-1:0]   push_len   [2],
	output logic                     room_two,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic signed [5:0]        out_code,
	output logic [POSITION_BITS-1:0] out_start,
	output logic [LENGTH_BITS-1:0]   out_len,
	output logic                     out_last
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic signed [5:0]        code_q  [DEPTH];
	logic [POSITION_BITS-1:0] start_q [DEPTH];
	logic [LENGTH_BITS-1:0]   len_q   [DEPTH];
	logic                     last_q  [DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     pop;
	logic [PTR_W-1:0]         wr_ptr1;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign room_two  = (CNT_W'(DEPTH) - cnt_q + CNT_W'(pop)) >= CNT_W'(2);
	assign wr_ptr1   = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);

	assign out_code  = code_q[rd_ptr_q];
	assign out_start = start_q[rd_ptr_q];
	assign out_len   = len_q[rd_ptr_q];
	assign out_last  = last_q[rd_ptr_q];

	// Store incoming tokens; the last one of a word carries the run mark
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			code_q[wr_ptr_q]  <= push_code[0];
			start_q[wr_ptr_q] <= push_start[0];
			len_q[wr_ptr_q]   <= push_len[0];
			last_q[wr_ptr_q]  <= (push_count == 2'd1);
		end
		if (push_count == 2'd2) begin
			code_q[wr_ptr1]  <= push_code[1];
			start_q[wr_ptr1] <= push_start[1];
			len_q[wr_ptr1]   <= push_len[1];
			last_q[wr_ptr1]  <= 1'b1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_count == 2'd1)
				wr_ptr_q <= wr_ptr1;
			else if (push_count == 2'd2)
				wr_ptr_q <= (wr_ptr1 == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr1 + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(push_count) - CNT_W'(pop);
		end
	end

	`MCL_ASSERT_IMPL(a_push_fits, clk, arst_n, push_count != 2'd0, room_two)
	`MCL_ASSERT_NEXT(a_cnt_tracks, clk, arst_n, push_count == 2'd0 && !pop, $stable(cnt_q))

endmodule

FILE: rtl/core/mini_c_lexer.sv
// Streaming lexer for a small C subset. One character word is taken per clock
// through the chars channel whenever the token queue has room for two tokens;
// whitespace is dropped without a token. Each word passes an input register
// and one combinational lexer step; its tokens are written into the token queue,
// whose head drives the tokens channel. A word closing a quote body, or ending
// a pending token while starting a new symbol, yields two tokens; the output
// port moves one token per cycle while tokens.ready is high, so such words use
// the port twice and that port sets the sustained rate, while the four-entry
// token queue only absorbs short bursts and output stalls. An is_end word flushes
// the pending token and returns the lexer to its reset state.
// Depends on mcl_pkg, mcl_if, mcl_lex_step, mcl_res_fifo and the macro header.
`include "mini_c_lexer_macros.svh"
module mini_c_lexer #(
	parameter int POSITION_BITS = mcl_pkg::POSITION_BITS_DEF,
	parameter int LENGTH_BITS   = mcl_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mcl_char_if.sink      chars,
	mcl_token_if.source   tokens
);

	logic                     valid_s1;
	logic [7:0]               char_s1;
	logic                     end_s1;
	logic                     fire_s1;
	logic                     room_two;

	mcl_pkg::lex_ctl_t        ctl_q;
	mcl_pkg::lex_ctl_t        ctl_nx;
	logic [POSITION_BITS-1:0] start_pos_q;
	logic [POSITION_BITS-1:0] start_pos_nx;
	logic [LENGTH_BITS-1:0]   run_len_q;
	logic [LENGTH_BITS-1:0]   run_len_nx;
	logic [POSITION_BITS-1:0] char_pos_q;
	logic [POSITION_BITS-1:0] char_pos_nx;

	logic [1:0]               res_count;
	logic signed [5:0]        res_code  [2];
	logic [POSITION_BITS-1:0] res_start [2];
	logic [LENGTH_BITS-1:0]   res_len   [2];
	logic [1:0]               push_count;

	assign fire_s1     = valid_s1 && room_two;
	assign chars.ready = !valid_s1 || room_two;
	assign push_count  = fire_s1 ? res_count : 2'd0;

	// Hold the input word until the lexer step can retire it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.in_char;
			end_s1  <= chars.is_end;
		end
	end

	// Advance lexer state when a word retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= '{mode: mcl_pkg::MODE_IDLE, kw_set: '0, rel_code: '0,
				quote_kind: 1'b0};
			start_pos_q <= '0;
			run_len_q   <= '0;
			char_pos_q  <= '0;
		end else if (fire_s1) begin
			ctl_q       <= ctl_nx;
			start_pos_q <= start_pos_nx;
			run_len_q   <= run_len_nx;
			char_pos_q  <= char_pos_nx;
		end
	end

	mcl_lex_step #(
		.POSITION_BITS (POSITION_BITS),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_step (
		.in_char      (char_s1),
		.is_end       (end_s1),
		.ctl          (ctl_q),
		.start_pos    (start_pos_q),
		.run_len      (run_len_q),
		.char_pos     (char_pos_q),
		.ctl_nx       (ctl_nx),
		.start_pos_nx (start_pos_nx),
		.run_len_nx   (run_len_nx),
		.char_pos_nx  (char_pos_nx),
		.res_count    (res_count),
		.res_code     (res_code),
		.res_start    (res_start),
		.res_len      (res_len)
	);

	mcl_res_fifo #(
		.POSITION_BITS (POSITION_BITS),
		.LENGTH_BITS   (LENGTH_BITS),
		.DEPTH         (mcl_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push_code  (res_code),
		.push_start (res_start),
		.push_len   (res_len),
		.room_two   (room_two),
		.out_ready  (tokens.ready),
		.out_valid  (tokens.valid),
		.out_code   (tokens.token_code),
		.out_start  (tokens.token_start),
		.out_len    (tokens.token_length),
		.out_last   (tokens.last_of_run)
	);

	`MCL_ASSERT_NEXT(a_end_resets, clk, arst_n, fire_s1 && end_s1, ctl_q.mode == mcl_pkg::MODE_IDLE && char_pos_q == '0)
	`MCL_ASSERT_NEXT(a_space_keeps_pos, clk, arst_n, fire_s1 && !end_s1 && mcl_pkg::is_space(char_s1), $stable(char_pos_q))
	`MCL_ASSERT_NEXT(a_stalled_word_held, clk, arst_n, valid_s1 && !room_two, valid_s1 && $stable(char_s1) && $stable(end_s1))

endmodule
